// ----- rtl/mfrag_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfrag_pkg
// Shared types and constants of the message fragmenter: function codes,
// command kinds, the command that travels from front to back end.
// ----------------------------------------------------------------------------
package mfrag_pkg;

    localparam int HEADER_ALLOWANCE = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [15:0] FRAGMENT_SIZE_RESET = 16'd1400;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // Kinds of command that the back end expands into output bytes
    typedef enum logic [1:0] {
        CMD_START,     // comp, flags, data id
        CMD_HDR_DATA,  // comp, flags, payload byte
        CMD_DATA,      // payload byte
        CMD_STRAY      // error result
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  comp_type;
        logic [7:0]  flags;
        logic [7:0]  tail_byte;
        logic        fragment_end;
        logic        message_end;
    } cmd_t;

    // Payload bytes that one fragment carries for a given fragment size
    function automatic logic [15:0] payload_of(input logic [15:0] size);
        logic [15:0] allow;
        allow = 16'(HEADER_ALLOWANCE);
        if (size > allow)
            payload_of = size - allow;
        else
            payload_of = 16'd1;
    endfunction

    localparam logic [15:0] PER_FRAG_RESET = payload_of(FRAGMENT_SIZE_RESET);

endpackage : mfrag_pkg
`default_nettype wire

// ----- rtl/message_fragmenter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// message_fragmenter
// Splits messages into fragments with inserted headers, one byte per result.
// ----------------------------------------------------------------------------
// A start transaction yields the three first-header bytes; each payload
// transaction yields its byte, preceded by a two-byte header when it opens a
// new fragment; a payload byte with no message open yields one error result.
// The output port moves one byte per cycle while out_ready is high; a two-entry
// command queue lets input transactions be taken while header bytes drain, and
// the input stalls only when that queue is full. fragment_size (cfg_wdata)
// takes effect at the next fragment that begins.
// ----------------------------------------------------------------------------
module message_fragmenter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [23:0] total_length,
    input  wire logic [7:0]  data_id,
    input  wire logic [7:0]  comp_type,
    input  wire logic [3:0]  channel,
    input  wire logic        relay,
    input  wire logic        system_flag,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             is_header,
    output logic             fragment_end,
    output logic             message_end,
    output logic             error,
    output logic             last_result
);
    import mfrag_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic not_empty;

    mfrag_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .total_length (total_length),
        .data_id      (data_id),
        .comp_type    (comp_type),
        .channel      (channel),
        .relay        (relay),
        .system_flag  (system_flag),
        .data_byte    (data_byte),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    mfrag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (not_empty)
    );

    mfrag_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .not_empty    (not_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_header    (is_header),
        .fragment_end (fragment_end),
        .message_end  (message_end),
        .error        (error),
        .last_result  (last_result)
    );

endmodule : message_fragmenter
`default_nettype wire

// ----- rtl/mfrag_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfrag_queue
// Short command queue between the front and back end.
// ----------------------------------------------------------------------------
module mfrag_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mfrag_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output mfrag_pkg::cmd_t      head_cmd,
    output logic                 not_empty
);
    import mfrag_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            bump = '0;
        else
            bump = p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule : mfrag_queue
`default_nettype wire

// ----- rtl/mfrag_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfrag_front
// Accepts input transactions, tracks message and fragment counts, and
// classifies each transaction into one command for the back end.
// ----------------------------------------------------------------------------
module mfrag_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [23:0] total_length,
    input  wire logic [7:0]  data_id,
    input  wire logic [7:0]  comp_type,
    input  wire logic [3:0]  channel,
    input  wire logic        relay,
    input  wire logic        system_flag,
    input  wire logic [7:0]  data_byte,
    input  wire logic        queue_full,
    output logic             push,
    output mfrag_pkg::cmd_t  push_cmd
);
    import mfrag_pkg::*;

    logic [15:0] per_frag_reg;
    logic [23:0] rem_reg, rem_next;
    logic [15:0] lif_reg, lif_next;
    logic [7:0]  comp_reg, comp_next;
    logic [5:0]  flags_reg, flags_next;
    logic        open_reg, open_next;

    logic        is_start;
    logic [23:0] src;
    logic [15:0] n;
    logic [23:0] rem_after;
    logic        new_frag;
    logic [15:0] lif_dec;
    logic [23:0] rem_eff;
    logic        fend;
    logic        mend;
    logic        last_mark;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign is_start = (func == FUNC_START);

    always_comb
    begin
        // One fragment share taken from either the new total or what is left
        src       = is_start ? total_length : rem_reg;
        n         = (src < {8'd0, per_frag_reg}) ? src[15:0] : per_frag_reg;
        rem_after = src - {8'd0, n};
        last_mark = (rem_after == '0);
        new_frag  = (lif_reg == '0);
        lif_dec   = (new_frag ? n : lif_reg) - 16'd1;
        rem_eff   = new_frag ? rem_after : rem_reg;
        fend      = (lif_dec == '0);
        mend      = fend && (rem_eff == '0);

        rem_next   = rem_reg;
        lif_next   = lif_reg;
        comp_next  = comp_reg;
        flags_next = flags_reg;
        open_next  = open_reg;

        push_cmd.comp_type    = comp_reg;
        push_cmd.flags        = {last_mark, 1'b0, flags_reg};
        push_cmd.tail_byte    = data_byte;
        push_cmd.fragment_end = fend;
        push_cmd.message_end  = mend;
        push_cmd.kind         = new_frag ? CMD_HDR_DATA : CMD_DATA;

        if (is_start)
        begin
            push_cmd.kind         = CMD_START;
            push_cmd.comp_type    = comp_type;
            push_cmd.flags        = {last_mark, 1'b1, system_flag, relay, channel};
            push_cmd.tail_byte    = data_id;
            push_cmd.fragment_end = (total_length == '0);
            push_cmd.message_end  = (total_length == '0);
            rem_next   = rem_after;
            lif_next   = n;
            comp_next  = comp_type;
            flags_next = {system_flag, relay, channel};
            open_next  = (total_length != '0);
        end
        else if (!open_reg)
        begin
            push_cmd.kind         = CMD_STRAY;
            push_cmd.tail_byte    = '0;
            push_cmd.fragment_end = 1'b0;
            push_cmd.message_end  = 1'b0;
        end
        else
        begin
            rem_next = rem_eff;
            lif_next = lif_dec;
            if (mend)
                open_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_frag_reg <= PER_FRAG_RESET;
            rem_reg      <= '0;
            lif_reg      <= '0;
            comp_reg     <= '0;
            flags_reg    <= '0;
            open_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                per_frag_reg <= payload_of(cfg_wdata);
            if (push)
            begin
                rem_reg   <= rem_next;
                lif_reg   <= lif_next;
                comp_reg  <= comp_next;
                flags_reg <= flags_next;
                open_reg  <= open_next;
            end
        end
    end

endmodule : mfrag_front
`default_nettype wire

// ----- rtl/mfrag_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfrag_back
// Expands queued commands into output bytes, one per cycle while the output
// is not stalled by out_ready, through a registered output stage.
// ----------------------------------------------------------------------------
module mfrag_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mfrag_pkg::cmd_t head_cmd,
    input  wire logic            not_empty,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_byte,
    output logic                 is_header,
    output logic                 fragment_end,
    output logic                 message_end,
    output logic                 error,
    output logic                 last_result
);
    import mfrag_pkg::*;

    localparam logic [1:0] POS_COMP  = 2'd0;
    localparam logic [1:0] POS_FLAGS = 2'd1;
    localparam logic [1:0] POS_TAIL  = 2'd2;

    logic [1:0] pos_reg, pos_next;
    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       hdr_reg, hdr_next;
    logic       fend_reg, mend_reg, err_reg, last_reg;

    logic       load;
    logic       has_hdr;
    logic [1:0] eff_pos;
    logic       at_tail;

    assign load    = not_empty && (!valid_reg || out_ready);
    assign has_hdr = (head_cmd.kind == CMD_START) || (head_cmd.kind == CMD_HDR_DATA);
    // Single-byte commands go straight to the tail position
    assign eff_pos = has_hdr ? pos_reg : POS_TAIL;
    assign at_tail = (eff_pos == POS_TAIL);
    assign pop     = load && at_tail;

    always_comb
    begin
        case (eff_pos)
            POS_COMP:  byte_next = head_cmd.comp_type;
            POS_FLAGS: byte_next = head_cmd.flags;
            default:   byte_next = head_cmd.tail_byte;
        endcase
        hdr_next = (head_cmd.kind == CMD_START) || (has_hdr && !at_tail);
        pos_next = pos_reg;
        if (load)
            pos_next = at_tail ? POS_COMP : pos_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_COMP;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            hdr_reg  <= hdr_next;
            fend_reg <= at_tail && head_cmd.fragment_end;
            mend_reg <= at_tail && head_cmd.message_end;
            err_reg  <= (head_cmd.kind == CMD_STRAY);
            last_reg <= at_tail;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign is_header    = hdr_reg;
    assign fragment_end = fend_reg;
    assign message_end  = mend_reg;
    assign error        = err_reg;
    assign last_result  = last_reg;

endmodule : mfrag_back
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for message_fragmenter. Directed and random message
// streams are pushed through the valid/ready input under varying stalls and
// fragment sizes. Each output byte is compared with a cycle-free prediction of
// the header and payload stream that the fragmenter should produce.
// ----------------------------------------------------------------------------
module tb_top;
    import mfrag_pkg::*;

    localparam logic [7:0] FLAG_FIRST  = 8'h40;
    localparam logic [7:0] FLAG_LAST   = 8'h80;
    localparam int         STALL_LIMIT = 3000;
    localparam int         HOLDOFF_LEN = 300;
    localparam int         NUM_PHASES  = 7;
    localparam int         PHASE_ITEMS = 55;

    typedef struct packed {
        logic        func;
        logic [23:0] total_length;
        logic [7:0]  data_id;
        logic [7:0]  comp_type;
        logic [3:0]  channel;
        logic        relay;
        logic        system_flag;
        logic [7:0]  data_byte;
    } frag_item_t;

    localparam int ITEM_W = $bits(frag_item_t);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       fragment_end;
        logic       message_end;
        logic       error;
        logic       last_result;
    } frag_byte_t;

    class fragment_tracker;
        logic [15:0] frag_size;
        logic [23:0] bytes_unassigned;
        logic [15:0] bytes_in_frag;
        logic [7:0]  comp_held;
        logic [7:0]  flags_held;
        bit          msg_open;
        frag_byte_t  bytes_due[$];
        int          failures;

        function new();
            frag_size        = FRAGMENT_SIZE_RESET;
            bytes_unassigned = '0;
            bytes_in_frag    = '0;
            comp_held        = '0;
            flags_held       = '0;
            msg_open         = 1'b0;
            failures         = 0;
        endfunction

        function void set_fragment_size(logic [15:0] size);
            frag_size = size;
        endfunction

        function int pending();
            return bytes_due.size();
        endfunction

        // Claim the next fragment's share of the message
        function void open_fragment();
            logic [23:0] share;
            share = (frag_size <= 16'(HEADER_ALLOWANCE)) ? 24'd1
                                                        : 24'(frag_size) - 24'(HEADER_ALLOWANCE);
            if (bytes_unassigned < share)
                share = bytes_unassigned;
            bytes_unassigned = bytes_unassigned - share;
            bytes_in_frag    = share[15:0];
        endfunction

        function void push(logic [7:0] b, logic hdr, logic fe, logic me, logic err,
                           logic last);
            frag_byte_t r;
            r.out_byte     = b;
            r.is_header    = hdr;
            r.fragment_end = fe;
            r.message_end  = me;
            r.error        = err;
            r.last_result  = last;
            bytes_due.push_back(r);
        endfunction

        function void take_input(frag_item_t it);
            logic [7:0] fl;
            logic       empty;
            logic       fe;
            logic       me;
            if (it.func == FUNC_START) begin
                empty            = (it.total_length == 24'd0);
                comp_held        = it.comp_type;
                flags_held       = {2'b00, it.system_flag, it.relay, it.channel};
                bytes_unassigned = it.total_length;
                open_fragment();
                fl = flags_held | FLAG_FIRST;
                if (bytes_unassigned == 24'd0)
                    fl = fl | FLAG_LAST;
                msg_open = !empty;
                if (empty)
                    bytes_in_frag = '0;
                push(comp_held, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                push(fl, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                push(it.data_id, 1'b1, empty, empty, 1'b0, 1'b1);
            end
            else if (!msg_open) begin
                push(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
            end
            else begin
                // first byte of a later fragment: insert the short header
                if (bytes_in_frag == 16'd0) begin
                    open_fragment();
                    fl = flags_held;
                    if (bytes_unassigned == 24'd0)
                        fl = fl | FLAG_LAST;
                    push(comp_held, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                    push(fl, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                end
                if (bytes_in_frag != 16'd0)
                    bytes_in_frag = bytes_in_frag - 16'd1;
                fe = (bytes_in_frag == 16'd0);
                me = fe && (bytes_unassigned == 24'd0);
                if (me)
                    msg_open = 1'b0;
                push(it.data_byte, 1'b0, fe, me, 1'b0, 1'b1);
            end
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                failures++;
            end
        endfunction

        function void check_byte(frag_byte_t got);
            frag_byte_t exp_b;
            if (bytes_due.size() == 0) begin
                $error("out_byte: expected none, got %0h", got.out_byte);
                failures++;
                return;
            end
            exp_b = bytes_due.pop_front();
            compare_field("out_byte", exp_b.out_byte, got.out_byte);
            compare_field("is_header", 8'(exp_b.is_header), 8'(got.is_header));
            compare_field("fragment_end", 8'(exp_b.fragment_end), 8'(got.fragment_end));
            compare_field("message_end", 8'(exp_b.message_end), 8'(got.message_end));
            compare_field("error", 8'(exp_b.error), 8'(got.error));
            compare_field("last_result", 8'(exp_b.last_result), 8'(got.last_result));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [23:0] total_length;
    logic [7:0]  data_id;
    logic [7:0]  comp_type;
    logic [3:0]  channel;
    logic        relay;
    logic        system_flag;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        is_header;
    logic        fragment_end;
    logic        message_end;
    logic        error;
    logic        last_result;

    fragment_tracker tracker;
    frag_item_t      cur_item;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              holdoff_req;
    int              gen_left;

    message_fragmenter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .total_length (total_length),
        .data_id      (data_id),
        .comp_type    (comp_type),
        .channel      (channel),
        .relay        (relay),
        .system_flag  (system_flag),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_header    (is_header),
        .fragment_end (fragment_end),
        .message_end  (message_end),
        .error        (error),
        .last_result  (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req > 0)
            begin
                out_ready = 1'b0;
                repeat (holdoff_req) @(negedge clk);
                holdoff_req = 0;
            end
            out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Note the input before checking the output so that same-edge ordering
    // between the two never matters
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tracker.take_input(cur_item);
        if (rst_n && out_valid && out_ready)
            tracker.check_byte({out_byte, is_header, fragment_end, message_end, error,
                                last_result});
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic frag_item_t mk_start(logic [23:0] len, logic [7:0] id,
                                            logic [7:0] comp, logic [3:0] ch,
                                            logic rly, logic sys);
        frag_item_t it;
        it              = '0;
        it.func         = FUNC_START;
        it.total_length = len;
        it.data_id      = id;
        it.comp_type    = comp;
        it.channel      = ch;
        it.relay        = rly;
        it.system_flag  = sys;
        it.data_byte    = 8'hFF;
        return it;
    endfunction

    function automatic frag_item_t mk_byte(logic [7:0] b);
        frag_item_t it;
        it           = '0;
        it.func      = FUNC_DATA;
        it.data_byte = b;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input frag_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cur_item     = it;
        func         = it.func;
        total_length = it.total_length;
        data_id      = it.data_id;
        comp_type    = it.comp_type;
        channel      = it.channel;
        relay        = it.relay;
        system_flag  = it.system_flag;
        data_byte    = it.data_byte;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Mostly well-formed messages with random content; some abandoned, some stray
    task automatic next_random(output frag_item_t it);
        int pick;
        int len;
        it   = ITEM_W'({$urandom(), $urandom()});
        pick = $urandom_range(0, 99);
        if (gen_left > 0 && pick < 96)
        begin
            it.func = FUNC_DATA;
            gen_left--;
        end
        else if (gen_left == 0 && pick < 15)
        begin
            it.func = FUNC_DATA;
        end
        else
        begin
            it.func = FUNC_START;
            pick    = $urandom_range(0, 99);
            if (pick < 10)
            begin
                it.total_length = '0;
                gen_left        = 0;
            end
            else if (pick < 16)
            begin
                it.total_length = 24'($urandom());
                gen_left        = $urandom_range(0, 6);
            end
            else
            begin
                len             = $urandom_range(1, 80);
                it.total_length = 24'(len);
                gen_left        = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len) : len;
            end
        end
    endtask

    task automatic write_size(input logic [15:0] size);
        cfg_we    = 1'b1;
        cfg_wdata = size;
        tracker.set_fragment_size(size);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        frag_item_t    it;
        int            sizes [NUM_PHASES];
        int            s_idle[NUM_PHASES];
        int            r_stall[NUM_PHASES];
        frag_item_t    directed[$];
        sizes   = '{30, 65535, 25, 0, 9, 40, 1400};
        s_idle  = '{0, 79, 0, 19, 0, 19, 0};
        r_stall = '{0, 0, 79, 19, 0, 19, 79};
        tracker        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 0;
        gen_left       = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        cur_item       = '0;
        func           = FUNC_START;
        total_length   = '0;
        data_id        = '0;
        comp_type      = '0;
        channel        = '0;
        relay          = 1'b0;
        system_flag    = 1'b0;
        data_byte      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: stray bytes, empty message, two-fragment message, abandoned
        // open message, all field extremes
        write_size(16'd25);
        directed.push_back(mk_byte(8'hFF));
        directed.push_back(mk_start(24'd0, 8'hFF, 8'hFF, 4'hF, 1'b1, 1'b1));
        directed.push_back(mk_byte(8'h00));
        directed.push_back(mk_start(24'd18, 8'h00, 8'h00, 4'h0, 1'b0, 1'b0));
        for (int i = 0; i < 18; i++)
            directed.push_back(mk_byte((i % 2 == 0) ? 8'h00 : 8'hFF));
        directed.push_back(mk_start(24'hFFFFFF, 8'hA5, 8'h5A, 4'h5, 1'b1, 1'b0));
        directed.push_back(mk_byte(8'h3C));
        directed.push_back(mk_start(24'd1, 8'h0F, 8'hF0, 4'hA, 1'b0, 1'b1));
        directed.push_back(mk_byte(8'hC3));
        foreach (directed[i])
            send_item(directed[i]);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_size(16'(sizes[p]));
            send_idle_pct  = s_idle[p];
            recv_stall_pct = r_stall[p];
            // hold the output off long enough to back the input up
            if (p == 4)
                holdoff_req = HOLDOFF_LEN;
            repeat (PHASE_ITEMS)
            begin
                next_random(it);
                send_item(it);
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : tb_top
`default_nettype wire
